/* src/mscg_pkg.sv */
// shared widths, register index codes and stage types for the color gradient
`default_nettype none

package mscg_pkg;

    localparam int POS_W        = 16;
    localparam int CHAN_W       = 8;
    localparam int COLOR_W      = 3 * CHAN_W;
    localparam int STOP_W       = POS_W + COLOR_W;
    localparam int COUNT_W      = 3;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = STOP_W;
    localparam int T_W          = POS_W + 1;
    localparam int PROD_W       = CHAN_W + T_W;

    localparam int NUM_STOPS_DEFAULT = 4;
    localparam int MAX_STOPS         = 4;

    localparam int DIV_STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES          = POS_W / DIV_STEPS_PER_STAGE;

    localparam logic [CFG_IDX_W-1:0] CFG_STOP_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_0     = 3'd1;

    localparam logic [COUNT_W-1:0] STOP_COUNT_RESET = 3'd2;
    localparam logic [STOP_W-1:0]  STOP_FIRST_RESET = '0;
    localparam logic [STOP_W-1:0]  STOP_OTHER_RESET = '1;

    typedef struct packed {
        logic [POS_W-1:0]   off;
        logic [POS_W-1:0]   span;
        logic [COLOR_W-1:0] ca;
        logic [COLOR_W-1:0] cb;
    } seg_t;

    typedef struct packed {
        logic [POS_W-1:0]   rem;
        logic [T_W-1:0]     quo;
        logic [POS_W-1:0]   span;
        logic [COLOR_W-1:0] ca;
        logic [COLOR_W-1:0] cb;
    } div_stage_t;

endpackage

`default_nettype wire

/* src/multi_stop_color_gradient.sv */
// multi-stop linear color gradient: stop search, pipelined divider, channel blend
// throughput: one transaction per cycle while m_ready holds up; depth is set by the 16-step restoring
// divider for the blend weight, two quotient bits per pipeline stage
// every stage has its own valid bit, so bubbles are squeezed out under back-pressure
// reset (aresetn low, synchronous) empties the pipeline and loads the register defaults
`default_nettype none

module multi_stop_color_gradient #(
    parameter int NUM_STOPS = mscg_pkg::NUM_STOPS_DEFAULT
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_wr_en,
    input  wire logic [mscg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [mscg_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [mscg_pkg::POS_W-1:0]       s_position,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [mscg_pkg::CHAN_W-1:0]           m_red,
    output logic [mscg_pkg::CHAN_W-1:0]           m_green,
    output logic [mscg_pkg::CHAN_W-1:0]           m_blue
);
    import mscg_pkg::*;

    localparam int HIT_W = (NUM_STOPS > 1) ? $clog2(NUM_STOPS) : 1;

    // configuration registers
    logic [COUNT_W-1:0] stop_count_reg;
    logic [STOP_W-1:0]  stop_reg [NUM_STOPS];

    // pipeline registers
    logic               in_valid_reg;
    logic [POS_W-1:0]   in_pos_reg;
    logic               seg_valid_reg;
    seg_t               seg_reg;
    seg_t               seg_next;
    logic [DIV_STAGES:0] dv_valid_reg;
    div_stage_t         dv_reg  [DIV_STAGES+1];
    div_stage_t         dv_next [DIV_STAGES+1];
    logic               mul_valid_reg;
    logic [PROD_W-1:0]  mul_a_reg [3];
    logic [PROD_W-1:0]  mul_b_reg [3];
    logic               m_valid_reg;
    logic [CHAN_W-1:0]  chan_reg  [3];
    logic [CHAN_W-1:0]  chan_next [3];

    // stage enables
    logic                out_en;
    logic                mul_en;
    logic [DIV_STAGES:0] dv_en;
    logic                seg_en;

    always_comb begin
        out_en = !m_valid_reg || m_ready;
        mul_en = !mul_valid_reg || out_en;
        dv_en[DIV_STAGES] = !dv_valid_reg[DIV_STAGES] || mul_en;
        for (int k = DIV_STAGES - 1; k >= 0; k--) begin
            dv_en[k] = !dv_valid_reg[k] || dv_en[k+1];
        end
        seg_en = !seg_valid_reg || dv_en[0];
    end

    assign s_ready = !in_valid_reg || seg_en;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stop_count_reg <= STOP_COUNT_RESET;
            for (int i = 0; i < NUM_STOPS; i++) begin
                stop_reg[i] <= (i == 0) ? STOP_FIRST_RESET : STOP_OTHER_RESET;
            end
        end else if (cfg_wr_en) begin
            if (cfg_index == CFG_STOP_COUNT) begin
                stop_count_reg <= cfg_data[COUNT_W-1:0];
            end
            for (int i = 0; i < NUM_STOPS; i++) begin
                if (cfg_index == CFG_STOP_0 + CFG_IDX_W'(i)) begin
                    stop_reg[i] <= cfg_data[STOP_W-1:0];
                end
            end
        end
    end

    // stop search and segment select
    always_comb begin : seg_blk
        logic [COUNT_W-1:0] cnt;
        logic [HIT_W-1:0]   hit;
        logic [HIT_W-1:0]   last;
        logic               found;
        logic [STOP_W-1:0]  cur;
        logic [STOP_W-1:0]  prv;
        logic [STOP_W-1:0]  lst;
        if (stop_count_reg == '0) begin
            cnt = COUNT_W'(1);
        end else if (stop_count_reg > COUNT_W'(NUM_STOPS)) begin
            cnt = COUNT_W'(NUM_STOPS);
        end else begin
            cnt = stop_count_reg;
        end
        last  = HIT_W'(cnt - COUNT_W'(1));
        found = 1'b0;
        hit   = '0;
        for (int i = NUM_STOPS - 1; i >= 0; i--) begin
            if (COUNT_W'(i) < cnt && in_pos_reg <= stop_reg[i][STOP_W-1:COLOR_W]) begin
                found = 1'b1;
                hit   = HIT_W'(i);
            end
        end
        cur = stop_reg[0];
        prv = stop_reg[0];
        lst = stop_reg[0];
        for (int i = 0; i < NUM_STOPS; i++) begin
            if (hit == HIT_W'(i)) begin
                cur = stop_reg[i];
            end
            if (i + 1 < NUM_STOPS && hit == HIT_W'(i + 1)) begin
                prv = stop_reg[i];
            end
            if (last == HIT_W'(i)) begin
                lst = stop_reg[i];
            end
        end
        // end segments bypass the blend with a zero weight
        if (!found) begin
            seg_next.off  = '0;
            seg_next.span = POS_W'(1);
            seg_next.ca   = lst[COLOR_W-1:0];
            seg_next.cb   = lst[COLOR_W-1:0];
        end else if (hit == '0) begin
            seg_next.off  = '0;
            seg_next.span = POS_W'(1);
            seg_next.ca   = cur[COLOR_W-1:0];
            seg_next.cb   = cur[COLOR_W-1:0];
        end else begin
            seg_next.off  = in_pos_reg - prv[STOP_W-1:COLOR_W];
            seg_next.span = cur[STOP_W-1:COLOR_W] - prv[STOP_W-1:COLOR_W];
            seg_next.ca   = prv[COLOR_W-1:0];
            seg_next.cb   = cur[COLOR_W-1:0];
        end
    end

    // divider: integer bit first, then two fraction bits per stage
    always_comb begin : div_blk
        div_stage_t       s;
        logic [POS_W:0]   r2;
        logic             q16;
        q16 = (seg_reg.off == seg_reg.span);
        dv_next[0].rem  = q16 ? '0 : seg_reg.off;
        dv_next[0].quo  = {{POS_W{1'b0}}, q16};
        dv_next[0].span = seg_reg.span;
        dv_next[0].ca   = seg_reg.ca;
        dv_next[0].cb   = seg_reg.cb;
        for (int k = 1; k <= DIV_STAGES; k++) begin
            s = dv_reg[k-1];
            for (int j = 0; j < DIV_STEPS_PER_STAGE; j++) begin
                r2 = {s.rem, 1'b0};
                if (r2 >= {1'b0, s.span}) begin
                    s.rem = POS_W'(r2 - {1'b0, s.span});
                    s.quo = {s.quo[T_W-2:0], 1'b1};
                end else begin
                    s.rem = r2[POS_W-1:0];
                    s.quo = {s.quo[T_W-2:0], 1'b0};
                end
            end
            dv_next[k] = s;
        end
    end

    // blend sum
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            chan_next[c] = CHAN_W'((mul_a_reg[c] + mul_b_reg[c]) >> POS_W);
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            seg_valid_reg <= 1'b0;
            dv_valid_reg  <= '0;
            mul_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (seg_en) begin
                seg_valid_reg <= in_valid_reg;
            end
            if (dv_en[0]) begin
                dv_valid_reg[0] <= seg_valid_reg;
            end
            for (int k = 1; k <= DIV_STAGES; k++) begin
                if (dv_en[k]) begin
                    dv_valid_reg[k] <= dv_valid_reg[k-1];
                end
            end
            if (mul_en) begin
                mul_valid_reg <= dv_valid_reg[DIV_STAGES];
            end
            if (out_en) begin
                m_valid_reg <= mul_valid_reg;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_ready) begin
            in_pos_reg <= s_position;
        end
        if (seg_en) begin
            seg_reg <= seg_next;
        end
        for (int k = 0; k <= DIV_STAGES; k++) begin
            if (dv_en[k]) begin
                dv_reg[k] <= dv_next[k];
            end
        end
        if (mul_en) begin
            for (int c = 0; c < 3; c++) begin
                mul_a_reg[c] <= PROD_W'(dv_reg[DIV_STAGES].ca[(2-c)*CHAN_W +: CHAN_W])
                                * PROD_W'((T_W'(1) << POS_W) - dv_reg[DIV_STAGES].quo);
                mul_b_reg[c] <= PROD_W'(dv_reg[DIV_STAGES].cb[(2-c)*CHAN_W +: CHAN_W])
                                * PROD_W'(dv_reg[DIV_STAGES].quo);
            end
        end
        if (out_en) begin
            for (int c = 0; c < 3; c++) begin
                chan_reg[c] <= chan_next[c];
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_red   = chan_reg[0];
    assign m_green = chan_reg[1];
    assign m_blue  = chan_reg[2];

    // input side only stalls when every stage holds a transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && seg_valid_reg && (&dv_valid_reg)
                      && mul_valid_reg && m_valid_reg && !m_ready))
        else $error("input stalled with a free pipeline stage");

    // offset never passes the span, so the weight stays within one
    assert property (@(posedge aclk) disable iff (!aresetn)
        seg_valid_reg |-> (seg_reg.off <= seg_reg.span && seg_reg.span != '0))
        else $error("segment offset beyond span");

    // divider remainder stays below the divisor
    assert property (@(posedge aclk) disable iff (!aresetn)
        dv_valid_reg[DIV_STAGES] |-> (dv_reg[DIV_STAGES].rem < dv_reg[DIV_STAGES].span))
        else $error("divider remainder out of range");

    // weight is at most one in 1.16 format
    assert property (@(posedge aclk) disable iff (!aresetn)
        dv_valid_reg[DIV_STAGES] |-> (dv_reg[DIV_STAGES].quo <= (T_W'(1) << POS_W)))
        else $error("blend weight above one");

endmodule

`default_nettype wire

/* verif/tb_multi_stop_color_gradient.sv */
// self-checking testbench for the multi-stop color gradient: directed and random stop setups
`timescale 1ns / 1ps

module tb_multi_stop_color_gradient;

    import mscg_pkg::*;

    localparam int N_STOPS      = 4;
    localparam int REG_SLOTS    = 4;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_CYCLES  = 24;
    localparam int STALL_LIMIT   = 4000;
    localparam int RAND_PHASES   = 12;
    localparam int PHASE_ITEMS   = 106;
    localparam int MAX_REPORTS   = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(CFG_STOP_0 + REG_SLOTS);

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_t;

    class gradient_scoreboard;
        logic [COUNT_W-1:0] count_q;
        logic [STOP_W-1:0]  stop_q [REG_SLOTS];
        rgb_t               expected_colors [$];
        int                 mismatches;

        function new();
            count_q = STOP_COUNT_RESET;
            stop_q[0] = STOP_FIRST_RESET;
            for (int i = 1; i < REG_SLOTS; i++) stop_q[i] = STOP_OTHER_RESET;
            mismatches = 0;
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_STOP_COUNT)
                count_q = data[COUNT_W-1:0];
            else if (idx >= CFG_STOP_0 && idx < CFG_UNUSED)
                stop_q[2'(idx - CFG_STOP_0)] = data[STOP_W-1:0];
        endfunction

        function rgb_t stop_color(input int i);
            rgb_t c;
            c = stop_q[i][COLOR_W-1:0];
            return c;
        endfunction

        function rgb_t blend(input logic [POS_W-1:0] pos);
            int          n;
            int          hit;
            bit          found;
            logic [63:0] p0, p1, span, off, t, a, b;
            logic [7:0]  chan [3];
            rgb_t        res;
            n = count_q;
            if (n < 1) n = 1;
            if (n > N_STOPS) n = N_STOPS;
            found = 1'b0;
            hit = 0;
            for (int i = 0; i < n; i++) begin
                if (!found && pos <= stop_q[i][STOP_W-1:COLOR_W]) begin
                    hit = i;
                    found = 1'b1;
                end
            end
            if (!found) return stop_color(n - 1);
            if (hit == 0) return stop_color(0);
            p0 = stop_q[hit-1][STOP_W-1:COLOR_W];
            p1 = stop_q[hit][STOP_W-1:COLOR_W];
            span = (p1 > p0) ? p1 - p0 : 64'd1;
            off = ({48'd0, pos} > p0) ? {48'd0, pos} - p0 : 64'd0;
            t = (off << 16) / span;
            if (t > 64'd65536) t = 64'd65536;
            for (int k = 0; k < 3; k++) begin
                a = (stop_q[hit-1] >> (16 - 8 * k)) & 64'hFF;
                b = (stop_q[hit] >> (16 - 8 * k)) & 64'hFF;
                chan[k] = 8'(((a * (64'd65536 - t) + b * t) >> 16) & 64'hFF);
            end
            res.red = chan[0];
            res.green = chan[1];
            res.blue = chan[2];
            return res;
        endfunction

        function void note_position(input logic [POS_W-1:0] pos);
            expected_colors.push_back(blend(pos));
        endfunction

        function void check_color(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                                  input logic [CHAN_W-1:0] b);
            rgb_t exp_c;
            if (expected_colors.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected transaction: r=%02h g=%02h b=%02h", r, g, b);
                return;
            end
            exp_c = expected_colors.pop_front();
            if (r !== exp_c.red || g !== exp_c.green || b !== exp_c.blue) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("mismatch: expected r=%02h g=%02h b=%02h, got r=%02h g=%02h b=%02h",
                             exp_c.red, exp_c.green, exp_c.blue, r, g, b);
            end
        endfunction

        function int pending();
            return expected_colors.size();
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    logic [POS_W-1:0]      s_position;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [CHAN_W-1:0]     m_red;
    logic [CHAN_W-1:0]     m_green;
    logic [CHAN_W-1:0]     m_blue;

    int send_idle_pct = 24;
    int recv_stall_pct = 70;
    int idle_cycles = 0;
    logic [POS_W-1:0] directed_q [$];

    gradient_scoreboard sb = new();

    multi_stop_color_gradient #(
        .NUM_STOPS(N_STOPS)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_position(s_position),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_red     (m_red),
        .m_green   (m_green),
        .m_blue    (m_blue)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_color(m_red, m_green, m_blue);
            if (s_valid && s_ready) sb.note_position(s_position);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            idle_cycles <= 0;
        end else if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("tb_multi_stop_color_gradient: FAIL");
                $finish;
            end
        end
    end

    task automatic send_position(input logic [POS_W-1:0] pos);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_position <= pos;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_directed();
        foreach (directed_q[i]) send_position(directed_q[i]);
        directed_q.delete();
    endtask

    // drop valid and wait for every transaction in flight to come out
    task automatic settle_pipeline();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        sb.write_reg(idx, data);
        @(posedge aclk);
    endtask

    task automatic write_count(input logic [COUNT_W-1:0] n);
        logic [63:0] r64;
        r64 = {$urandom, $urandom};
        write_register(CFG_STOP_COUNT, {r64[CFG_DATA_W-1:COUNT_W], n});
    endtask

    function automatic logic [COLOR_W-1:0] pick_color();
        int r;
        r = $urandom_range(9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return COLOR_W'($urandom);
    endfunction

    task automatic load_random_stops(input int phase);
        logic [POS_W-1:0] pos_a [REG_SLOTS];
        logic [POS_W-1:0] tmp;
        logic [COUNT_W-1:0] n;
        int kind;
        int base;
        kind = $urandom_range(9);
        base = $urandom_range(65532);
        for (int i = 0; i < REG_SLOTS; i++) pos_a[i] = POS_W'($urandom);
        case (kind)
            0: for (int i = 0; i < REG_SLOTS; i++) pos_a[i] = '0;
            1: for (int i = 0; i < REG_SLOTS; i++) pos_a[i] = '1;
            2: ;
            3: for (int i = 0; i < REG_SLOTS; i++) pos_a[i] = POS_W'(base + i);
            4: pos_a[2] = pos_a[1];
            default: ;
        endcase
        if (kind != 2) begin
            for (int i = 0; i < REG_SLOTS; i++) begin
                for (int j = 0; j < REG_SLOTS - 1 - i; j++) begin
                    if (pos_a[j] > pos_a[j+1]) begin
                        tmp = pos_a[j];
                        pos_a[j] = pos_a[j+1];
                        pos_a[j+1] = tmp;
                    end
                end
            end
        end
        if (phase == 0) n = 3'd1;
        else if (phase == 1) n = 3'd4;
        else if ($urandom_range(9) < 8) n = COUNT_W'($urandom_range(1, 4));
        else n = COUNT_W'($urandom_range(0, 7));
        write_count(n);
        for (int i = 0; i < REG_SLOTS; i++)
            write_register(CFG_IDX_W'(CFG_STOP_0 + i), {pos_a[i], pick_color()});
        if ($urandom_range(3) == 0) begin
            tmp = POS_W'($urandom);
            write_register(CFG_IDX_W'(CFG_UNUSED + $urandom_range(2)),
                           {tmp, COLOR_W'($urandom)});
        end
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [POS_W-1:0] pick_position();
        int r;
        int i;
        logic [POS_W-1:0] lo, hi;
        r = $urandom_range(99);
        if (r < 40) return POS_W'($urandom);
        if (r < 75) begin
            i = $urandom_range(REG_SLOTS - 1);
            return sb.stop_q[i][STOP_W-1:COLOR_W] + POS_W'($urandom_range(4)) - POS_W'(2);
        end
        if (r < 85) return ($urandom_range(1) != 0) ? '1 : '0;
        i = $urandom_range(1, REG_SLOTS - 1);
        lo = sb.stop_q[i-1][STOP_W-1:COLOR_W];
        hi = sb.stop_q[i][STOP_W-1:COLOR_W];
        return POS_W'($urandom_range(hi, lo));
    endfunction

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_position = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset stops: black at 0 to white at the top
        directed_q = '{16'h0000, 16'h0001, 16'h8000, 16'hFFFF};
        send_directed();
        settle_pipeline();

        // four stops with two at the same position
        write_count(3'd4);
        write_register(CFG_IDX_W'(CFG_STOP_0 + 0), {16'h1000, 24'h102030});
        write_register(CFG_IDX_W'(CFG_STOP_0 + 1), {16'h4000, 24'hFF00FF});
        write_register(CFG_IDX_W'(CFG_STOP_0 + 2), {16'h4000, 24'h00FF00});
        write_register(CFG_IDX_W'(CFG_STOP_0 + 3), {16'hC000, 24'hFFFFFF});
        cfg_wr_en <= 1'b0;
        directed_q = '{16'h0000, 16'h1000, 16'h1001, 16'h2800, 16'h4000,
                       16'h4001, 16'hBFFF, 16'hC000, 16'hC001, 16'hFFFF};
        send_directed();
        settle_pipeline();

        // zero count acts as one stop
        write_count(3'd0);
        cfg_wr_en <= 1'b0;
        directed_q = '{16'h0FFF, 16'h2000};
        send_directed();
        settle_pipeline();

        // count above the stop limit saturates
        write_count(3'd7);
        cfg_wr_en <= 1'b0;
        directed_q = '{16'hC001, 16'h8000};
        send_directed();
        settle_pipeline();

        // stops out of order
        write_count(3'd4);
        write_register(CFG_IDX_W'(CFG_STOP_0 + 0), {16'h8000, 24'h0000FF});
        write_register(CFG_IDX_W'(CFG_STOP_0 + 1), {16'h2000, 24'hFF0000});
        write_register(CFG_IDX_W'(CFG_STOP_0 + 2), {16'hA000, 24'h00FF00});
        write_register(CFG_IDX_W'(CFG_STOP_0 + 3), {16'h1000, 24'h808080});
        cfg_wr_en <= 1'b0;
        directed_q = '{16'h9000, 16'h1000, 16'hB000};
        send_directed();
        settle_pipeline();

        // writes past the last stop register change nothing
        for (int k = 0; k < 3; k++)
            write_register(CFG_IDX_W'(CFG_UNUSED + k), {16'hFFFF, 24'hFFFFFF});
        cfg_wr_en <= 1'b0;
        directed_q = '{16'h9000, 16'hFFFF};
        send_directed();
        settle_pipeline();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            if (ph < 4) begin
                send_idle_pct = 24;
                recv_stall_pct = 70;
            end else if (ph < 8) begin
                send_idle_pct = 70;
                recv_stall_pct = 24;
            end else begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            load_random_stops(ph);
            for (int i = 0; i < PHASE_ITEMS; i++) send_position(pick_position());
            settle_pipeline();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("tb_multi_stop_color_gradient: PASS");
        end else begin
            $display("tb_multi_stop_color_gradient: FAIL");
        end
        $finish;
    end

endmodule

/* multi_stop_color_gradient.f */
src/mscg_pkg.sv
src/multi_stop_color_gradient.sv
verif/tb_multi_stop_color_gradient.sv
